// ===== sv/quaternion_to_euler_angles_defines.svh =====
// assertion macros for the quaternion to euler angles block
// used by quaternion_to_euler_angles.sv, no other dependencies
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// condition must lead to consequence in the same cycle
`define Q2E_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: implication");

// condition must never be seen
`define Q2E_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition");

`endif

// ===== sv/q2e_pkg.sv =====
// shared widths, bus types and the arctangent table of the quaternion to euler block
// no dependencies
package q2e_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_TABLE_LEN    = 24;
   localparam int IN_W              = 16;
   localparam int ANGLE_W           = 16;
   localparam int PW                = 32;   // product of two parts
   localparam int AW                = 34;   // cordic operands before growth
   localparam int XW                = 37;   // cordic datapath
   localparam int ZW                = 32;   // angle accumulator
   localparam int SQRT_BITS         = 29;   // root bits of a value up to 2^56
   localparam int REM_W             = 58;
   localparam int ROOT_W            = 30;
   localparam int ASQ_W             = 56;
   localparam int MAG_W             = 28;

   localparam logic signed [AW-1:0] ONE_Q28  = AW'(2**28);
   localparam logic signed [AW-1:0] HALF_Q28 = AW'(2**27);

   // one vector under rotation
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } lane_type;

   typedef struct packed {
      logic conv;
      logic zero_a;
      logic zero_b;
      logic sat_pos;
      logic sat_neg;
   } flags_type;

   typedef struct packed {
      lane_type             lane_a;
      lane_type             lane_b;
      flags_type            flags;
      logic signed [XW-1:0] asin_y;
      logic [REM_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
   } sqrt_bus_type;

   typedef struct packed {
      lane_type  lane_a;
      lane_type  lane_b;
      lane_type  lane_s;
      flags_type flags;
   } cordic_bus_type;

   // atan(2^-i) in 1/65536 of a hundredth of a degree
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = ZW'(294912000);
         1:  v = ZW'(174096719);
         2:  v = ZW'(91987925);
         3:  v = ZW'(46694507);
         4:  v = ZW'(23437865);
         5:  v = ZW'(11730358);
         6:  v = ZW'(5866610);
         7:  v = ZW'(2933484);
         8:  v = ZW'(1466764);
         9:  v = ZW'(733385);
         10: v = ZW'(366693);
         11: v = ZW'(183346);
         12: v = ZW'(91673);
         13: v = ZW'(45837);
         14: v = ZW'(22918);
         15: v = ZW'(11459);
         16: v = ZW'(5730);
         17: v = ZW'(2865);
         18: v = ZW'(1432);
         19: v = ZW'(716);
         20: v = ZW'(358);
         21: v = ZW'(179);
         22: v = ZW'(90);
         23: v = ZW'(45);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/q2e_sqrt_cell.sv =====
// one bit of the pipelined integer square root, carries the cordic lanes along
// depends on q2e_pkg
module q2e_sqrt_cell import q2e_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         valid_in,
   input  sqrt_bus_type bus_in,
   output logic         valid_out,
   output sqrt_bus_type bus_out
);

   logic         valid_ff;
   sqrt_bus_type bus_ff, bus_in_next;
   logic [REM_W-1:0] trial;

   // try this root bit against the remainder
   always_comb begin
      trial = ((REM_W'(bus_in.root) << 1) + (REM_W'(1) << BIT)) << BIT;
      bus_in_next = bus_in;
      if (bus_in.rem >= trial) begin
         bus_in_next.rem  = bus_in.rem - trial;
         bus_in_next.root = bus_in.root | (ROOT_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bus_ff <= bus_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign bus_out   = bus_ff;

endmodule

// ===== sv/q2e_cordic_cell.sv =====
// one vectoring cordic stage for the three angle lanes
// depends on q2e_pkg
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           valid_in,
   input  cordic_bus_type bus_in,
   output logic           valid_out,
   output cordic_bus_type bus_out
);

   logic           valid_ff;
   cordic_bus_type bus_ff, bus_in_next;

   // rotate toward the x axis by atan(2^-STAGE)
   function automatic lane_type rotate(input lane_type l);
      lane_type r;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      dx = l.y >>> STAGE;
      dy = l.x >>> STAGE;
      if (l.y >= 0) begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + atan_entry(STAGE);
      end else begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - atan_entry(STAGE);
      end
      return r;
   endfunction

   always_comb begin
      bus_in_next        = bus_in;
      bus_in_next.lane_a = rotate(bus_in.lane_a);
      bus_in_next.lane_b = rotate(bus_in.lane_b);
      bus_in_next.lane_s = rotate(bus_in.lane_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bus_ff <= bus_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign bus_out   = bus_ff;

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// quaternion to euler angles, fully pipelined: one quaternion in and one set of
// angles out per clock while the result side does not stall (three front
// stages, 29 square root cells for the asin path, the cordic cells, one output
// register); a stall on the result side holds the whole pipeline.
// depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell and the defines header
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [IN_W-1:0]    req_q_w,
   input  logic signed [IN_W-1:0]    req_q_x,
   input  logic signed [IN_W-1:0]    req_q_y,
   input  logic signed [IN_W-1:0]    req_q_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_roll_angle,
   output logic signed [ANGLE_W-1:0] rsp_pitch_angle,
   output logic signed [ANGLE_W-1:0] rsp_yaw_angle
);

   logic enable;
   logic conv_ff;

   // stage 1 products
   logic                 s1_valid_ff, s1_conv_ff;
   logic signed [PW-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_zz_ff;
   logic signed [PW-1:0] p_wy_ff, p_xz_ff, p_wz_ff, p_xy_ff;

   // stage 2 operands
   logic                 s2_valid_ff, s2_conv_ff;
   logic signed [AW-1:0] ay_ff, ax_ff, as_ff, by_ff, bx_ff;
   logic signed [AW-1:0] ay_in, ax_in, as_in, by_in, bx_in;
   logic signed [AW-1:0] e_wx, e_yz, e_xx, e_yy, e_zz, e_wy, e_xz, e_wz, e_xy;

   // stage 3 prerotation and asin square
   logic                 s3_valid_ff;
   lane_type             lane_a_ff, lane_b_ff;
   flags_type            flags_ff, flags_in;
   logic signed [AW-1:0] asin_y_ff;
   logic [ASQ_W-1:0]     asq_ff;
   logic signed [AW-1:0] as_mag;

   // cell chains
   logic         sq_valid [SQRT_BITS+1];
   sqrt_bus_type sq_bus   [SQRT_BITS+1];
   logic           co_valid [CORDIC_STAGES+1];
   cordic_bus_type co_bus   [CORDIC_STAGES+1];

   // output register
   logic                      rsp_valid_ff;
   logic                      out_conv_ff;
   logic signed [ANGLE_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [ANGLE_W-1:0] ang_a, ang_b, ang_s;
   cordic_bus_type            last;

   // whole pipeline moves unless a finished result is held
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   // convention register
   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff <= 1'b0;
      end else if (csr_write_enable) begin
         conv_ff <= csr_write_data;
      end
   end

   // stage 1: the nine part products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_conv_ff <= conv_ff;
         p_wx_ff <= PW'(req_q_w) * PW'(req_q_x);
         p_yz_ff <= PW'(req_q_y) * PW'(req_q_z);
         p_xx_ff <= PW'(req_q_x) * PW'(req_q_x);
         p_yy_ff <= PW'(req_q_y) * PW'(req_q_y);
         p_zz_ff <= PW'(req_q_z) * PW'(req_q_z);
         p_wy_ff <= PW'(req_q_w) * PW'(req_q_y);
         p_xz_ff <= PW'(req_q_x) * PW'(req_q_z);
         p_wz_ff <= PW'(req_q_w) * PW'(req_q_z);
         p_xy_ff <= PW'(req_q_x) * PW'(req_q_y);
      end
   end

   // stage 2: atan2 and asin operands for the selected order
   always_comb begin
      e_wx = AW'(p_wx_ff);
      e_yz = AW'(p_yz_ff);
      e_xx = AW'(p_xx_ff);
      e_yy = AW'(p_yy_ff);
      e_zz = AW'(p_zz_ff);
      e_wy = AW'(p_wy_ff);
      e_xz = AW'(p_xz_ff);
      e_wz = AW'(p_wz_ff);
      e_xy = AW'(p_xy_ff);
      if (!s1_conv_ff) begin
         ay_in = (e_wx + e_yz) <<< 1;
         ax_in = ONE_Q28 - ((e_xx + e_yy) <<< 1);
         as_in = (e_wy - e_xz) <<< 1;
         by_in = (e_wz + e_xy) <<< 1;
         bx_in = ONE_Q28 - ((e_yy + e_zz) <<< 1);
      end else begin
         ay_in = e_wy - e_xz;
         ax_in = HALF_Q28 - e_xx - e_yy;
         as_in = (e_wx + e_yz) <<< 1;
         by_in = e_wz - e_xy;
         bx_in = HALF_Q28 - e_xx - e_zz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_conv_ff <= s1_conv_ff;
         ay_ff <= ay_in;
         ax_ff <= ax_in;
         as_ff <= as_in;
         by_ff <= by_in;
         bx_ff <= bx_in;
      end
   end

   // move a left half plane vector into the right half plane
   function automatic lane_type prerotate(input logic signed [AW-1:0] y,
                                          input logic signed [AW-1:0] x);
      lane_type l;
      logic signed [XW-1:0] xe;
      logic signed [XW-1:0] ye;
      xe = XW'(x);
      ye = XW'(y);
      if (x < 0) begin
         if (y >= 0) begin
            l.x = ye;
            l.y = -xe;
            l.z = atan_entry(0) <<< 1;
         end else begin
            l.x = -ye;
            l.y = xe;
            l.z = -(atan_entry(0) <<< 1);
         end
      end else begin
         l.x = xe;
         l.y = ye;
         l.z = '0;
      end
      return l;
   endfunction

   // stage 3: prerotation, special case flags, asin argument squared
   always_comb begin
      as_mag           = (as_ff < 0) ? -as_ff : as_ff;
      flags_in.conv    = s2_conv_ff;
      flags_in.zero_a  = (ay_ff == 0) && (ax_ff == 0);
      flags_in.zero_b  = (by_ff == 0) && (bx_ff == 0);
      flags_in.sat_pos = as_ff >= ONE_Q28;
      flags_in.sat_neg = as_ff <= -ONE_Q28;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_a_ff <= prerotate(ay_ff, ax_ff);
         lane_b_ff <= prerotate(by_ff, bx_ff);
         flags_ff  <= flags_in;
         asin_y_ff <= as_ff;
         asq_ff    <= ASQ_W'(as_mag[MAG_W-1:0]) * ASQ_W'(as_mag[MAG_W-1:0]);
      end
   end

   // square root chain on 2^56 minus the squared asin argument
   always_comb begin
      sq_valid[0]       = s3_valid_ff;
      sq_bus[0].lane_a  = lane_a_ff;
      sq_bus[0].lane_b  = lane_b_ff;
      sq_bus[0].flags   = flags_ff;
      sq_bus[0].asin_y  = XW'(asin_y_ff);
      sq_bus[0].rem     = (REM_W'(1) << ASQ_W) - REM_W'(asq_ff);
      sq_bus[0].root    = '0;
   end

   for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
      q2e_sqrt_cell #(
         .BIT(SQRT_BITS - 1 - g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .valid_in (sq_valid[g]),
         .bus_in   (sq_bus[g]),
         .valid_out(sq_valid[g+1]),
         .bus_out  (sq_bus[g+1])
      );
   end

   // cordic chain, asin lane starts from (root, argument)
   always_comb begin
      co_valid[0]        = sq_valid[SQRT_BITS];
      co_bus[0].lane_a   = sq_bus[SQRT_BITS].lane_a;
      co_bus[0].lane_b   = sq_bus[SQRT_BITS].lane_b;
      co_bus[0].flags    = sq_bus[SQRT_BITS].flags;
      co_bus[0].lane_s.x = XW'(sq_bus[SQRT_BITS].root);
      co_bus[0].lane_s.y = sq_bus[SQRT_BITS].asin_y;
      co_bus[0].lane_s.z = '0;
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      q2e_cordic_cell #(
         .STAGE(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .valid_in (co_valid[g]),
         .bus_in   (co_bus[g]),
         .valid_out(co_valid[g+1]),
         .bus_out  (co_bus[g+1])
      );
   end

   // round to hundredths of a degree and clamp
   function automatic logic signed [ANGLE_W-1:0] to_centideg(
         input logic signed [ZW-1:0] z);
      logic signed [ZW:0] t;
      logic signed [ZW:0] c;
      t = (ZW+1)'(z) + (ZW+1)'(32768);
      c = t >>> 16;
      if (c > (ZW+1)'(18000)) begin
         c = (ZW+1)'(18000);
      end else if (c < -(ZW+1)'(18000)) begin
         c = -(ZW+1)'(18000);
      end
      return c[ANGLE_W-1:0];
   endfunction

   // output selection with the zero vector and asin saturation cases
   always_comb begin
      last  = co_bus[CORDIC_STAGES];
      ang_a = last.flags.zero_a ? '0 : to_centideg(last.lane_a.z);
      ang_b = last.flags.zero_b ? '0 : to_centideg(last.lane_b.z);
      priority if (last.flags.sat_pos) begin
         ang_s = ANGLE_W'(9000);
      end else if (last.flags.sat_neg) begin
         ang_s = -ANGLE_W'(9000);
      end else begin
         ang_s = to_centideg(last.lane_s.z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= co_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_conv_ff <= last.flags.conv;
         yaw_ff      <= ang_b;
         if (!last.flags.conv) begin
            roll_ff  <= ang_a;
            pitch_ff <= ang_s;
         end else begin
            pitch_ff <= ang_a;
            roll_ff  <= ang_s;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   // angles stay within half a turn
   `Q2E_ASSERT_NEVER(a_angle_range, clock, reset, rsp_valid_ff && (roll_ff > 18000 || roll_ff < -18000 || pitch_ff > 18000 || pitch_ff < -18000 || yaw_ff > 18000 || yaw_ff < -18000))
   // asin axis stays within a quarter turn in ned order
   `Q2E_ASSERT_IMPLY(a_asin_ned, clock, reset, rsp_valid_ff && !out_conv_ff, pitch_ff <= 9000 && pitch_ff >= -9000)
   // asin axis stays within a quarter turn in gimbal order
   `Q2E_ASSERT_IMPLY(a_asin_gimbal, clock, reset, rsp_valid_ff && out_conv_ff, roll_ff <= 9000 && roll_ff >= -9000)
   // the root leaving the chain is the floor square root
   `Q2E_ASSERT_IMPLY(a_sqrt_rem, clock, reset, sq_valid[SQRT_BITS], sq_bus[SQRT_BITS].rem <= (REM_W'(sq_bus[SQRT_BITS].root) << 1))

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the quaternion to euler angles block
// depends on q2e_pkg and the quaternion_to_euler_angles rtl; holds its own angle predictor
module tb_top import q2e_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  N_STAGES   = CORDIC_STAGES_DEF;
   localparam int  DRAIN_WAIT = 33 + N_STAGES + 20;
   localparam int  STALL_MAX  = 3000;
   localparam int  RAND_PER   = 460;
   localparam longint UNIT    = 64'sd1 <<< 28;

   typedef struct packed {
      logic signed [IN_W-1:0] w;
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] yaw;
   } euler_type;

   // arctangent of 2^-i in 1/65536 of a hundredth of a degree
   localparam longint ARCTAN [0:23] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45};

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic                      csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [IN_W-1:0]    req_q_w, req_q_x, req_q_y, req_q_z;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [ANGLE_W-1:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   logic      order_gimbal;
   logic      calm;
   int        error_count;
   int        quats_sent;
   int        angles_checked;
   int        quiet_cycles;
   int        send_gap;
   int        hold_gap;

   quaternion_to_euler_angles dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_q_w(req_q_w), .req_q_x(req_q_x), .req_q_y(req_q_y), .req_q_z(req_q_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_roll_angle(rsp_roll_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_yaw_angle(rsp_yaw_angle)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- angle predictor ----------------

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // vectoring rotation, result rounded to hundredths and clamped
   function automatic longint vector_angle(longint y, longint x);
      longint acc;
      longint t;
      longint dx;
      longint dy;
      longint c;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t;
            acc = 2 * ARCTAN[0];
         end else begin
            t = x; x = -y; y = t;
            acc = -2 * ARCTAN[0];
         end
      end
      for (int i = 0; i < N_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; acc = acc + ARCTAN[i];
         end else begin
            x = x - dx; y = y + dy; acc = acc - ARCTAN[i];
         end
      end
      c = (acc + 32768) >>> 16;
      if (c > 18000) c = 18000;
      if (c < -18000) c = -18000;
      return c;
   endfunction

   // arcsine with saturation at plus or minus ninety degrees
   function automatic longint arcsine(longint a);
      longint unsigned rest;
      if (a >= UNIT) return 9000;
      if (a <= -UNIT) return -9000;
      rest = (64'd1 << 56) - longint'(a * a);
      return vector_angle(a, longint'(int_sqrt(rest)));
   endfunction

   function automatic euler_type predict_angles(quat_type q, logic gimbal);
      longint w, x, y, z;
      euler_type e;
      w = q.w; x = q.x; y = q.y; z = q.z;
      if (!gimbal) begin
         e.roll  = ANGLE_W'(vector_angle(2 * (w * x + y * z), UNIT - 2 * (x * x + y * y)));
         e.pitch = ANGLE_W'(arcsine(2 * (w * y - x * z)));
         e.yaw   = ANGLE_W'(vector_angle(2 * (w * z + x * y), UNIT - 2 * (y * y + z * z)));
      end else begin
         e.pitch = ANGLE_W'(vector_angle(w * y - x * z, UNIT / 2 - x * x - y * y));
         e.roll  = ANGLE_W'(arcsine(2 * (w * x + y * z)));
         e.yaw   = ANGLE_W'(vector_angle(w * z - x * y, UNIT / 2 - x * x - z * z));
      end
      return e;
   endfunction

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         // record the prediction for every transfer
         if (req_valid && !req_stall) begin
            expected_angles.push_back(predict_angles(
               quat_type'({req_q_w, req_q_x, req_q_y, req_q_z}), order_gimbal));
            quats_sent <= quats_sent + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_quats.size() != 0) begin
               quat_type q;
               q = pending_quats.pop_front();
               req_q_w   <= q.w;
               req_q_x   <= q.x;
               req_q_y   <= q.y;
               req_q_z   <= q.z;
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // convention tracking follows the register write
   always @(posedge clock) begin
      if (reset)
         order_gimbal <= 1'b0;
      else if (csr_write_enable)
         order_gimbal <= csr_write_data;
   end

   // ---------------- response monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected transfer: roll %0d pitch %0d yaw %0d",
                      rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle);
               error_count <= error_count + 1;
            end else begin
               euler_type e;
               int bad;
               e = expected_angles.pop_front();
               bad = 0;
               if (rsp_roll_angle !== e.roll) begin
                  $error("roll_angle expected %0d actual %0d", e.roll, rsp_roll_angle);
                  bad++;
               end
               if (rsp_pitch_angle !== e.pitch) begin
                  $error("pitch_angle expected %0d actual %0d", e.pitch, rsp_pitch_angle);
                  bad++;
               end
               if (rsp_yaw_angle !== e.yaw) begin
                  $error("yaw_angle expected %0d actual %0d", e.yaw, rsp_yaw_angle);
                  bad++;
               end
               error_count <= error_count + bad;
               angles_checked <= angles_checked + 1;
            end
         end
         // random stall bursts on the result side
         if (hold_gap > 0) begin
            hold_gap  <= hold_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            hold_gap  <= $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("timeout: no transfer for %0d cycles", STALL_MAX);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   function automatic quat_type make_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = IN_W'(w); q.x = IN_W'(x); q.y = IN_W'(y); q.z = IN_W'(z);
      return q;
   endfunction

   // near-unit quaternion with three random parts and a solved fourth part in a random position
   function automatic quat_type unit_quat();
      int x, y, z;
      longint unsigned rest;
      int w;
      x = $urandom_range(0, 18000) - 9000;
      y = $urandom_range(0, 18000) - 9000;
      z = $urandom_range(0, 18000) - 9000;
      rest = longint'(UNIT) - longint'(x * x + y * y + z * z);
      w = int'(int_sqrt(rest)) + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) w = -w;
      case ($urandom_range(0, 3))
         0: return make_quat(w, x, y, z);
         1: return make_quat(x, w, y, z);
         2: return make_quat(x, y, w, z);
         default: return make_quat(x, y, z, w);
      endcase
   endfunction

   task automatic load_directed();
      pending_quats.push_back(make_quat(16384, 0, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 0));
      pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
      pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
      pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
      // asin argument past plus and minus one, and just below one
      pending_quats.push_back(make_quat(16384, 16384, 16384, 0));
      pending_quats.push_back(make_quat(16384, -16384, -16384, 0));
      pending_quats.push_back(make_quat(11585, 11585, 11585, 0));
      // zero vectors and half turns into the arctangent, then a negated identity
      pending_quats.push_back(make_quat(0, 8192, 8192, 0));
      pending_quats.push_back(make_quat(0, 8192, 0, 8192));
      pending_quats.push_back(make_quat(0, 16384, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 16384));
      pending_quats.push_back(make_quat(0, 0, 16384, 0));
      pending_quats.push_back(make_quat(-16384, 0, 0, 0));
   endtask

   task automatic load_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 6)
            pending_quats.push_back(unit_quat());
         else
            pending_quats.push_back(quat_type'({$urandom, $urandom}));
      end
   endtask

   task automatic wait_drained();
      while (pending_quats.size() != 0 || expected_angles.size() != 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_convention(logic v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic phase_order [0:3];
      phase_order = '{1'b0, 1'b1, 1'b0, 1'b1};
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_valid        = 1'b0;
      req_q_w = '0; req_q_x = '0; req_q_y = '0; req_q_z = '0;
      rsp_stall        = 1'b0;
      calm             = 1'b0;
      error_count      = 0;
      quats_sent       = 0;
      angles_checked   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // each phase: set the convention, then directed transfers (first two phases only) and random transfers
      for (int p = 0; p < 4; p++) begin
         write_convention(phase_order[p]);
         if (p == 3) calm = 1'b1;
         if (p < 2) load_directed();
         load_random(RAND_PER);
         wait_drained();
      end

      $display("sent %0d quaternions, checked %0d angle sets", quats_sent, angles_checked);
      $display("both angle conventions covered, with random stalls on either side");
      if (error_count == 0 && expected_angles.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_sqrt_cell.sv
sv/q2e_cordic_cell.sv
sv/quaternion_to_euler_angles.sv
verif/tb_top.sv
